// ----- rtl/core/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: request and
// response payloads, operation codes and register defaults.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_WIDTH       = 32;
    localparam int VALUE_WIDTH     = 32;
    localparam int CAP_WIDTH       = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_SET = 1'b1
    } func_t;

    typedef struct packed {
        func_t                  func;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] read_value;
        logic                   evicted;
        logic [KEY_WIDTH-1:0]   evicted_key;
    } rsp_t;

endpackage

// ----- rtl/core/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Get and set requests in, one response per request out.
//
//   port        dir  width             meaning
//   req*        in   1+KEY+VALUE       get/set transaction (valid/ready)
//   rsp*        out  1+VALUE+1+KEY     hit, read value, eviction report
//   cfg_we      in   1 + 5 data        capacity register write
//
// One transaction per cycle while the response is not stalled: requests land
// in an input register, and the key match, rank update and replacement are
// computed combinationally from it into the response register, which raises
// rsp_valid when it loads.
// Reset empties the cache (all entries invalid, capacity 16); no clear pass.
// A stalled response holds the held request; req_ready drops only when
// both registers are full and rsp_ready is low.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lkv_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lkv_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [lkv_pkg::CAP_WIDTH-1:0] cfg_wdata
);

    logic [lkv_pkg::CAP_WIDTH-1:0] cap_reg;
    lkv_pkg::req_t                 req_hold_reg;
    logic                          req_full_reg;
    logic                          req_full_next;
    lkv_pkg::rsp_t                 rsp_reg;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    lkv_pkg::rsp_t                 store_rsp;
    logic                          advance;
    logic                          req_accept;

    // move the held request into the response register
    assign advance        = req_full_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready      = !req_full_reg || advance;
    assign req_accept     = req_valid && req_ready;
    assign req_full_next  = req_accept || (req_full_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);

    lkv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .req      (req_hold_reg),
        .capacity (cap_reg),
        .rsp      (store_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkv_pkg::CAP_RESET;
            req_full_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            req_full_reg  <= req_full_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_hold_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= store_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/lkv_store.sv -----
// ----------------------------------------------------------------------------
// lkv_store
// Entry storage with parallel key match, recency ranks and replacement.
// Forms the response for the held request and commits its update on fire.
// ----------------------------------------------------------------------------
module lkv_store #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  lkv_pkg::req_t                  req,
    input  logic [lkv_pkg::CAP_WIDTH-1:0]  capacity,
    output lkv_pkg::rsp_t                  rsp
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (lkv_pkg::CAP_WIDTH > OCC_W) ? lkv_pkg::CAP_WIDTH : OCC_W;

    logic [lkv_pkg::KEY_WIDTH-1:0]   key_reg [ENTRIES];
    logic [lkv_pkg::VALUE_WIDTH-1:0] val_reg [ENTRIES];
    logic [RANK_W-1:0]               rank_reg [ENTRIES];
    logic [RANK_W-1:0]               rank_next [ENTRIES];
    logic [ENTRIES-1:0]              valid_reg;
    logic [ENTRIES-1:0]              valid_next;
    logic [OCC_W-1:0]                occ_reg;
    logic [OCC_W-1:0]                occ_next;

    logic [ENTRIES-1:0]              match_vec;
    logic [ENTRIES-1:0]              lru_vec;
    logic [ENTRIES-1:0]              free_vec;
    logic [ENTRIES-1:0]              write_vec;
    logic [ENTRIES-1:0]              age_vec;
    logic                            hit;
    logic                            is_set;
    logic                            full;
    logic                            set_miss;
    logic [RANK_W-1:0]               hit_rank;
    logic [RANK_W-1:0]               lru_rank;
    logic [lkv_pkg::VALUE_WIDTH-1:0] hit_value;
    logic [lkv_pkg::KEY_WIDTH-1:0]   lru_key;
    logic [CMP_W-1:0]                cap_ext;
    logic [CMP_W-1:0]                cap_eff;

    assign is_set   = (req.func == lkv_pkg::FUNC_SET);
    assign lru_rank = RANK_W'(occ_reg - OCC_W'(1));

    // clamp capacity to 1..ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        priority if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign full = (CMP_W'(occ_reg) >= cap_eff);

    // keys are unique among valid entries, so the match is at most one-hot
    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        lru_key   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req.key);
            lru_vec[i]   = valid_reg[i] && (rank_reg[i] == lru_rank);
            hit_rank     = hit_rank  | (match_vec[i] ? rank_reg[i] : '0);
            hit_value    = hit_value | (match_vec[i] ? val_reg[i]  : '0);
            lru_key      = lru_key   | (lru_vec[i]   ? key_reg[i]  : '0);
        end
    end

    assign hit      = |match_vec;
    assign set_miss = is_set && !hit;
    // lowest-numbered invalid slot
    assign free_vec = ~valid_reg & (valid_reg + ENTRIES'(1));

    always_comb
    begin
        priority if (hit)
        begin
            write_vec = match_vec;
        end
        else if (full)
        begin
            write_vec = lru_vec;
        end
        else
        begin
            write_vec = free_vec;
        end
    end

    // on a hit age only the more recent entries; on an insert age everyone
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_vec[i] = valid_reg[i] && (!hit || (rank_reg[i] < hit_rank));
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (fire && (hit || is_set))
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (write_vec[i])
                begin
                    rank_next[i] = '0;
                end
                else if (age_vec[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            if (set_miss && !full)
            begin
                valid_next = valid_reg | free_vec;
                occ_next   = occ_reg + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (fire && is_set && write_vec[i])
            begin
                val_reg[i] <= req.value;
                if (!hit)
                begin
                    key_reg[i] <= req.key;
                end
            end
        end
    end

    always_comb
    begin
        rsp.hit         = hit;
        rsp.read_value  = (hit && !is_set) ? hit_value : '0;
        rsp.evicted     = set_miss && full;
        rsp.evicted_key = (set_miss && full) ? lru_key : '0;
    end

endmodule
